FILE: rtl/lmcfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmcfb_pkg;

   localparam int COLS_PER_DEV = 8;
   localparam int ROW_BITS     = COLS_PER_DEV * 8;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_SHIFT = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_BCAST = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_SH_READ,
      ST_SH_WRITE,
      ST_REF_READ,
      ST_REF_EMIT
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [4:0]  column_index;
      logic [7:0]  data_byte;
      logic [3:0]  reg_address;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  target_device;
      logic [3:0]  word_address;
      logic [7:0]  word_data;
      logic        broadcast;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_all;
   } mem_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/lmcfb_store.sv
`timescale 1ns / 1ps
`default_nettype none

module lmcfb_store #(
   parameter int  DEVICE_COUNT = 4,
   localparam int DEV_W        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  lmcfb_pkg::mem_ctl_type       ctl,
   input  wire  [DEV_W-1:0]             rd_addr,
   input  wire  [DEV_W-1:0]             wr_addr,
   input  wire  [lmcfb_pkg::ROW_BITS-1:0] wr_data,
   output logic [lmcfb_pkg::ROW_BITS-1:0] rd_data
);

   // One entry per device: eight column bytes, column 0 of the device lowest.
   logic [lmcfb_pkg::ROW_BITS-1:0] mem [DEVICE_COUNT];
   logic [DEVICE_COUNT-1:0]        valid_ff;
   logic [lmcfb_pkg::ROW_BITS-1:0] rdata_ff;
   logic                           rvalid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // An entry never written since reset or the last clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset || ctl.clr_all) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         rvalid_ff <= valid_ff[rd_addr] && !ctl.clr_all;
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/lmcfb_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lmcfb_seq #(
   parameter int  DEVICE_COUNT = 4,
   localparam int DEV_W        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  lmcfb_pkg::req_item_type        req_item,
   output logic                           rsp_valid,
   output lmcfb_pkg::rsp_item_type        rsp_item,
   output lmcfb_pkg::mem_ctl_type         mem_ctl,
   output logic [DEV_W-1:0]               rd_addr,
   output logic [DEV_W-1:0]               wr_addr,
   output logic [lmcfb_pkg::ROW_BITS-1:0] wr_data,
   input  wire  [lmcfb_pkg::ROW_BITS-1:0] rd_data
);

   localparam logic [6:0] TOTAL_COLS = 7'(DEVICE_COUNT * lmcfb_pkg::COLS_PER_DEV);
   localparam logic [DEV_W-1:0] LAST_DEV = DEV_W'(DEVICE_COUNT - 1);

   lmcfb_pkg::state_type     state_ff, state_in;
   lmcfb_pkg::req_item_type  item_ff, item_in;
   logic [DEV_W-1:0]         dev_ff, dev_in;
   logic [2:0]               row_ff, row_in;
   logic [7:0]               carry_ff, carry_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   lmcfb_pkg::rsp_item_type  rsp_ff, rsp_in;

   logic                     accept;
   logic                     idx_in_range;
   logic [DEV_W-1:0]         idx_dev;
   logic [DEV_W-1:0]         dev_next;
   logic [lmcfb_pkg::ROW_BITS-1:0] merged;
   logic [7:0]               row_byte;

   assign accept       = start && (state_ff == lmcfb_pkg::ST_IDLE);
   assign busy         = (state_ff != lmcfb_pkg::ST_IDLE);
   assign idx_in_range = ({2'b00, req_item.column_index} < TOTAL_COLS);
   assign idx_dev      = DEV_W'(item_ff.column_index >> 3);
   assign dev_next     = DEV_W'(dev_ff + 1'b1);

   // Column byte replaced in place for a single-column write.
   always_comb begin
      merged = rd_data;
      for (int k = 0; k < lmcfb_pkg::COLS_PER_DEV; k++) begin
         if (3'(k) == item_ff.column_index[2:0]) begin
            merged[8*k +: 8] = item_ff.data_byte;
         end
      end
   end

   // Row j of a device takes bit j of each column, column order reversed.
   always_comb begin
      row_byte = '0;
      for (int k = 0; k < lmcfb_pkg::COLS_PER_DEV; k++) begin
         row_byte[7-k] = rd_data[8*k + int'(row_ff)];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmcfb_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_item.action)
                  lmcfb_pkg::ACT_WRITE: begin
                     state_in = idx_in_range ? lmcfb_pkg::ST_WR_READ
                                             : lmcfb_pkg::ST_REF_READ;
                  end
                  lmcfb_pkg::ACT_SHIFT: state_in = lmcfb_pkg::ST_SH_READ;
                  lmcfb_pkg::ACT_CLEAR: state_in = lmcfb_pkg::ST_REF_READ;
                  lmcfb_pkg::ACT_BCAST: state_in = lmcfb_pkg::ST_IDLE;
                  default:              state_in = lmcfb_pkg::ST_IDLE;
               endcase
            end
         end
         lmcfb_pkg::ST_WR_READ:  state_in = lmcfb_pkg::ST_WR_WRITE;
         lmcfb_pkg::ST_WR_WRITE: state_in = lmcfb_pkg::ST_REF_READ;
         lmcfb_pkg::ST_SH_READ:  state_in = lmcfb_pkg::ST_SH_WRITE;
         lmcfb_pkg::ST_SH_WRITE: begin
            state_in = (dev_ff == LAST_DEV) ? lmcfb_pkg::ST_REF_READ
                                            : lmcfb_pkg::ST_SH_READ;
         end
         lmcfb_pkg::ST_REF_READ: state_in = lmcfb_pkg::ST_REF_EMIT;
         lmcfb_pkg::ST_REF_EMIT: begin
            if (row_ff == 3'd7 && dev_ff == LAST_DEV) begin
               state_in = lmcfb_pkg::ST_IDLE;
            end
         end
         default: state_in = lmcfb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      dev_in       = dev_ff;
      row_in       = row_ff;
      carry_in     = carry_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_ctl      = '0;
      rd_addr      = dev_ff;
      wr_addr      = dev_ff;
      wr_data      = merged;
      unique case (state_ff)
         lmcfb_pkg::ST_IDLE: begin
            if (accept) begin
               item_in  = req_item;
               dev_in   = '0;
               row_in   = '0;
               carry_in = '0;
               if (req_item.action == lmcfb_pkg::ACT_CLEAR) begin
                  mem_ctl.clr_all = 1'b1;
               end
               if (req_item.action == lmcfb_pkg::ACT_BCAST) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.target_device = '0;
                  rsp_in.word_address  = req_item.reg_address;
                  rsp_in.word_data     = req_item.data_byte;
                  rsp_in.broadcast     = 1'b1;
                  rsp_in.last          = 1'b1;
               end
            end
         end
         lmcfb_pkg::ST_WR_READ: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = idx_dev;
         end
         lmcfb_pkg::ST_WR_WRITE: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = idx_dev;
            wr_data       = merged;
         end
         lmcfb_pkg::ST_SH_READ: begin
            mem_ctl.rd_en = 1'b1;
         end
         lmcfb_pkg::ST_SH_WRITE: begin
            // The top column of each device carries into the next device.
            mem_ctl.wr_en = 1'b1;
            wr_data       = {rd_data[lmcfb_pkg::ROW_BITS-9:0], carry_ff};
            carry_in      = rd_data[lmcfb_pkg::ROW_BITS-1 -: 8];
            dev_in        = (dev_ff == LAST_DEV) ? '0 : dev_next;
         end
         lmcfb_pkg::ST_REF_READ: begin
            mem_ctl.rd_en = 1'b1;
            row_in        = '0;
         end
         lmcfb_pkg::ST_REF_EMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.target_device = 2'(dev_ff);
            rsp_in.word_address  = 4'(row_ff) + 4'd1;
            rsp_in.word_data     = row_byte;
            rsp_in.broadcast     = 1'b0;
            rsp_in.last          = (row_ff == 3'd7) && (dev_ff == LAST_DEV);
            row_in               = row_ff + 3'd1;
            // Fetch the next device during its predecessor's last row.
            if (row_ff == 3'd7 && dev_ff != LAST_DEV) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = dev_next;
               dev_in        = dev_next;
            end
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmcfb_pkg::ST_IDLE;
         dev_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dev_ff       <= dev_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      carry_ff <= carry_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/led_matrix_chain_frame_builder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame builder for a daisy chain of 8x8 LED matrix drivers.
// A command is taken on req_item when start is high and busy is low. Actions
// write one column, shift all columns up by one, clear all columns, or
// broadcast one register word to every device.
// Write, shift and clear end with a refresh: one chain frame per display row,
// 8*DEVICE_COUNT frames, each shown on rsp_item for one cycle with rsp_valid
// high; the final frame of a command has last set.
// The column store is one memory entry per device with a registered read.
// A refresh reads one entry per device and streams its eight rows, one frame
// per cycle; the next entry is fetched during the last row, so frames are
// back to back. Before the refresh, a write reads and writes back the entry
// of its column (no access when the column lies beyond the chain), and a
// shift reads and writes back each entry in turn, carrying between devices;
// a clear goes straight to the refresh. The store has a single read port and a
// single write port. A broadcast gives its frame the next cycle and keeps busy
// low. Reset empties the store through per-entry valid bits, so no clearing
// pass is needed. The receiver cannot stall; frames are not held.

module led_matrix_chain_frame_builder_unit #(
   parameter int DEVICE_COUNT = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  lmcfb_pkg::req_item_type  req_item,
   output logic                     rsp_valid,
   output lmcfb_pkg::rsp_item_type  rsp_item
);

   localparam int DEV_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

   lmcfb_pkg::mem_ctl_type         mem_ctl;
   logic [DEV_W-1:0]               rd_addr;
   logic [DEV_W-1:0]               wr_addr;
   logic [lmcfb_pkg::ROW_BITS-1:0] wr_data;
   logic [lmcfb_pkg::ROW_BITS-1:0] rd_data;

   lmcfb_seq #(
      .DEVICE_COUNT(DEVICE_COUNT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .mem_ctl   (mem_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   lmcfb_store #(
      .DEVICE_COUNT(DEVICE_COUNT)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lmcfb_pkg::*;

   localparam int DEVICES    = 4;
   localparam int CHAIN_COLS = DEVICES * COLS_PER_DEV;

   typedef struct {
      req_item_type cmd;
      int           idle_after;
      bit           drain_first;
   } pending_cmd_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   pending_cmd_type cmd_queue[$];
   rsp_item_type    frames_due[$];
   logic [7:0]      shadow_cols[CHAIN_COLS];
   int              mismatches = 0;
   int              idle_left = 0;
   int              cur_idle = 0;
   bit              no_idle = 0;
   pending_cmd_type next_cmd;
   rsp_item_type    want;

   led_matrix_chain_frame_builder_unit #(.DEVICE_COUNT(DEVICES)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Updates the column shadow for one command and queues the frames it yields.
   task automatic model_command(input req_item_type cmd);
      rsp_item_type frame;
      logic [7:0]   row;
      int           c;
      case (cmd.action)
         ACT_WRITE: begin
            if (cmd.column_index < CHAIN_COLS)
               shadow_cols[cmd.column_index] = cmd.data_byte;
         end
         ACT_SHIFT: begin
            for (c = CHAIN_COLS - 1; c > 0; c--)
               shadow_cols[c] = shadow_cols[c - 1];
            shadow_cols[0] = '0;
         end
         ACT_CLEAR: begin
            for (c = 0; c < CHAIN_COLS; c++)
               shadow_cols[c] = '0;
         end
         default: ;
      endcase
      if (cmd.action == ACT_BCAST) begin
         frame.target_device = '0;
         frame.word_address  = cmd.reg_address;
         frame.word_data     = cmd.data_byte;
         frame.broadcast     = 1'b1;
         frame.last          = 1'b1;
         frames_due.push_back(frame);
      end else begin
         // Transpose each device block: column k feeds bit 7-k of every row.
         for (int d = 0; d < DEVICES; d++) begin
            for (int j = 0; j < COLS_PER_DEV; j++) begin
               row = '0;
               for (int k = 0; k < COLS_PER_DEV; k++)
                  row[7 - k] = shadow_cols[d * COLS_PER_DEV + k][j];
               frame.target_device = d[1:0];
               frame.word_address  = 4'(j + 1);
               frame.word_data     = row;
               frame.broadcast     = 1'b0;
               frame.last          = (d * COLS_PER_DEV + j == CHAIN_COLS - 1);
               frames_due.push_back(frame);
            end
         end
      end
   endtask

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 4);
      else
         return $urandom_range(15, 60);
   endfunction

   task automatic queue_cmd(input action_type act, input logic [4:0] col,
                            input logic [7:0] data, input logic [3:0] addr,
                            input bit drain);
      pending_cmd_type p;
      p.cmd.action       = act;
      p.cmd.column_index = col;
      p.cmd.data_byte    = data;
      p.cmd.reg_address  = addr;
      p.idle_after       = pick_idle();
      p.drain_first      = drain;
      cmd_queue.push_back(p);
   endtask

   // Command driver: holds start until the beat is taken, then idles a while.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
      end else begin
         if (start && !busy) begin
            model_command(req_item);
            idle_left = cur_idle;
         end
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].drain_first && frames_due.size() != 0)) begin
               next_cmd = cmd_queue.pop_front();
               cur_idle = next_cmd.idle_after;
               start    <= 1'b1;
               req_item <= next_cmd.cmd;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Frame monitor: every strobed frame must match the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (frames_due.size() == 0) begin
            $display("%0t: unexpected frame, expected none, got %h", $time, rsp_item);
            mismatches++;
         end else begin
            want = frames_due.pop_front();
            if (rsp_item.target_device !== want.target_device) begin
               $display("%0t: target_device expected %0d got %0d", $time,
                        want.target_device, rsp_item.target_device);
               mismatches++;
            end
            if (rsp_item.word_address !== want.word_address) begin
               $display("%0t: word_address expected %h got %h", $time,
                        want.word_address, rsp_item.word_address);
               mismatches++;
            end
            if (rsp_item.word_data !== want.word_data) begin
               $display("%0t: word_data expected %h got %h", $time,
                        want.word_data, rsp_item.word_data);
               mismatches++;
            end
            if (rsp_item.broadcast !== want.broadcast) begin
               $display("%0t: broadcast expected %b got %b", $time,
                        want.broadcast, rsp_item.broadcast);
               mismatches++;
            end
            if (rsp_item.last !== want.last) begin
               $display("%0t: last expected %b got %b", $time,
                        want.last, rsp_item.last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int         r;
      action_type act;
      for (int c = 0; c < CHAIN_COLS; c++)
         shadow_cols[c] = '0;

      // Directed part: corner columns, device edges, all actions.
      queue_cmd(ACT_WRITE, 5'd0,  8'hFF, 4'h0, 0);
      queue_cmd(ACT_WRITE, 5'd31, 8'hFF, 4'hF, 0);
      queue_cmd(ACT_WRITE, 5'd7,  8'h01, 4'h5, 0);
      queue_cmd(ACT_WRITE, 5'd8,  8'h80, 4'hA, 0);
      queue_cmd(ACT_WRITE, 5'd15, 8'hA5, 4'h3, 0);
      queue_cmd(ACT_WRITE, 5'd16, 8'h5A, 4'hC, 0);
      queue_cmd(ACT_BCAST, 5'd0,  8'h00, 4'h0, 0);
      queue_cmd(ACT_BCAST, 5'd31, 8'hFF, 4'hF, 0);
      queue_cmd(ACT_SHIFT, 5'd0,  8'h00, 4'h0, 0);
      queue_cmd(ACT_SHIFT, 5'd31, 8'hFF, 4'hF, 0);
      queue_cmd(ACT_WRITE, 5'd30, 8'h3C, 4'h7, 0);
      queue_cmd(ACT_SHIFT, 5'd12, 8'h12, 4'h2, 0);
      queue_cmd(ACT_BCAST, 5'd5,  8'h5A, 4'h9, 1);
      queue_cmd(ACT_WRITE, 5'd23, 8'h81, 4'h1, 0);
      queue_cmd(ACT_CLEAR, 5'd31, 8'hFF, 4'hF, 0);
      queue_cmd(ACT_SHIFT, 5'd0,  8'h00, 4'h0, 0);
      queue_cmd(ACT_WRITE, 5'd24, 8'hFF, 4'h4, 0);
      queue_cmd(ACT_BCAST, 5'd1,  8'hC3, 4'hB, 0);
      queue_cmd(ACT_BCAST, 5'd2,  8'h0F, 4'hC, 0);
      queue_cmd(ACT_CLEAR, 5'd0,  8'h00, 4'h0, 1);
      queue_cmd(ACT_WRITE, 5'd0,  8'h00, 4'h8, 0);

      for (int i = 0; i < 390; i++) begin
         if (i % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 50)
            act = ACT_WRITE;
         else if (r < 65)
            act = ACT_SHIFT;
         else if (r < 70)
            act = ACT_CLEAR;
         else
            act = ACT_BCAST;
         queue_cmd(act, 5'($urandom), 8'($urandom), 4'($urandom),
                   $urandom_range(0, 49) == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (cmd_queue.size() != 0 || start);
      while (frames_due.size() != 0)
         @(negedge clock);
      repeat (60) @(negedge clock);

      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
